// File: rtl/core/ntc_pkg.sv
// Shared constants, types and helper functions for the NTC thermistor converter.
package ntc_pkg;

  localparam int SAMPLE_FULL_SCALE = 4095;

  localparam logic [31:0] CLAMP_LO = 32'(SAMPLE_FULL_SCALE);
  localparam logic [31:0] CLAMP_HI = 32'(329 * SAMPLE_FULL_SCALE);
  localparam logic [31:0] CLAMP_MUL = 32'd330;
  localparam logic [15:0] FULL_SCALE = 16'(SAMPLE_FULL_SCALE);
  localparam logic [15:0] RATIO_LIMIT = 16'd329;

  localparam int LOG_STEPS = 30;
  localparam int DIV_STAGES = 64;
  localparam int T1_BITS = 47;

  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [T1_BITS-1:0] T1_DIVIDEND = 47'd100 << 40;
  localparam logic [63:0] TQ_DIVIDEND = 64'h8000_0000_0000_0000;
  localparam logic [63:0] TQ_LIMIT = 64'd40000 << 23;
  localparam logic [46:0] KELVIN_OFFSET = 47'd27315 << 23;
  localparam logic [15:0] RECIP_100 = 16'd41943;

  localparam logic REG_BETA = 1'b0;
  localparam logic REG_T0 = 1'b1;

  localparam logic [13:0] BETA_RESET = 14'd3950;
  localparam logic [15:0] T0_RESET = 16'd29815;

  localparam logic [15:0] TEMP_MAX = 16'h7FFF;
  localparam logic [15:0] TEMP_MIN = 16'h8000;

  typedef logic [33:0] logval_t;
  typedef logic [63:0] dword_t;
  typedef logic [47:0] divisor_t;

  function automatic logic [3:0] msb16(input logic [15:0] x);
    logic [3:0] k;
    k = 4'd0;
    for (int i = 1; i < 16; i++) begin
      if (x[i]) begin
        k = 4'(i);
      end
    end
    return k;
  endfunction

  function automatic logic [30:0] log_norm(input logic [15:0] x);
    logic [3:0] k;
    k = msb16(x);
    return 31'({15'b0, x} << (5'd30 - {1'b0, k}));
  endfunction

endpackage

// File: rtl/core/ntc_thermistor_to_celsius_top.sv
// NTC thermistor B-equation converter: raw divider sample to whole degrees Celsius.
// Throughput: one transaction per cycle, taken whenever start is high and busy is low.
// Depth comes from the 30 squaring steps of the log2 unit and two 64-stage dividers.
// Reset: synchronous; clears the pipeline valid bits and restores both registers.
// 1/T0 is recomputed bit by bit after reset and after a T0 write, in the background.
// Results carry no back-pressure: the receiver takes each on the cycle done is high.
module ntc_thermistor_to_celsius_top import ntc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] raw_sample,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [15:0] wr_data,
  output logic        done,
  output logic signed [15:0] temperature_c,
  output logic        saturated
);

  logic [13:0] beta;
  logic [13:0] beta_eff;
  logic [15:0] t1_div;
  logic [5:0]  t1_cnt;
  logic [15:0] t1_rem;
  logic [T1_BITS-1:0] t1_q;
  logic [16:0] t1_sh;

  assign beta_eff = (beta == 14'd0) ? 14'd1 : beta;
  assign t1_sh = {t1_rem, T1_DIVIDEND[t1_cnt - 6'd1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b1;
      beta   <= BETA_RESET;
      t1_div <= T0_RESET;
      t1_cnt <= 6'(T1_BITS);
      t1_rem <= 16'd0;
      t1_q   <= '0;
    end else begin
      busy <= 1'b0;
      if (wr_en && wr_index == REG_BETA) begin
        beta <= wr_data[13:0];
      end
      if (wr_en && wr_index == REG_T0) begin
        t1_div <= (wr_data == 16'd0) ? 16'd1 : wr_data;
        t1_cnt <= 6'(T1_BITS);
        t1_rem <= 16'd0;
        t1_q   <= '0;
      end else if (t1_cnt != 6'd0) begin
        t1_cnt <= t1_cnt - 6'd1;
        if (t1_sh >= {1'b0, t1_div}) begin
          t1_rem <= 16'(t1_sh - {1'b0, t1_div});
          t1_q   <= {t1_q[T1_BITS-2:0], 1'b1};
        end else begin
          t1_rem <= t1_sh[15:0];
          t1_q   <= {t1_q[T1_BITS-2:0], 1'b0};
        end
      end
    end
  end

  logic [31:0] scaled;
  logic        s0_valid;
  logic [15:0] s0_num;
  logic [15:0] s0_den;

  assign scaled = 32'(raw_sample) * CLAMP_MUL;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
    if (scaled < CLAMP_LO) begin
      s0_num <= 16'd1;
      s0_den <= RATIO_LIMIT;
    end else if (scaled > CLAMP_HI) begin
      s0_num <= RATIO_LIMIT;
      s0_den <= 16'd1;
    end else begin
      s0_num <= {4'b0, raw_sample};
      s0_den <= FULL_SCALE - {4'b0, raw_sample};
    end
  end

  logic    lg_valid;
  logval_t lg_mag;
  logic    lg_neg;

  ntc_log2 u_log2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s0_valid),
    .num       (s0_num),
    .den       (s0_den),
    .out_valid (lg_valid),
    .mag       (lg_mag),
    .neg       (lg_neg)
  );

  logic [63:0] ln_prod;
  logic        ln_valid;
  logic [33:0] ln_mag;
  logic        ln_neg;

  assign ln_prod = 64'(lg_mag) * 64'(LN2_Q30);

  always_ff @(posedge clk) begin
    if (rst) begin
      ln_valid <= 1'b0;
    end else begin
      ln_valid <= lg_valid;
    end
    ln_mag <= ln_prod[63:30];
    ln_neg <= lg_neg;
  end

  logic   d1_valid;
  dword_t d1_quo;
  logic   d1_neg;

  ntc_div u_div_ln (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ln_valid),
    .dividend  ({20'b0, ln_mag, 10'b0}),
    .divisor   ({34'b0, beta_eff}),
    .tag_in    (ln_neg),
    .out_valid (d1_valid),
    .quotient  (d1_quo),
    .tag_out   (d1_neg)
  );

  logic signed [48:0] inv;
  logic               iv_valid;
  divisor_t           iv_div;
  logic               iv_nonpos;

  always_comb begin
    if (d1_neg) begin
      inv = $signed({2'b0, t1_q}) - $signed({5'b0, d1_quo[43:0]});
    end else begin
      inv = $signed({2'b0, t1_q}) + $signed({5'b0, d1_quo[43:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iv_valid <= 1'b0;
    end else begin
      iv_valid <= d1_valid;
    end
    iv_nonpos <= inv[48] || (inv == 49'sd0);
    iv_div    <= (inv[48] || (inv == 49'sd0)) ? 48'd1 : inv[47:0];
  end

  logic   d2_valid;
  dword_t d2_quo;
  logic   d2_nonpos;

  ntc_div u_div_t (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (iv_valid),
    .dividend  (TQ_DIVIDEND),
    .divisor   (iv_div),
    .tag_in    (iv_nonpos),
    .out_valid (d2_valid),
    .quotient  (d2_quo),
    .tag_out   (d2_nonpos)
  );

  logic [45:0] k_prod;
  logic        p1_valid;
  logic        p1_sat;
  logic [46:0] p1_c;

  assign k_prod = 46'(d2_quo[38:0]) * 46'd100;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= d2_valid;
    end
    p1_sat <= d2_nonpos || (d2_quo >= TQ_LIMIT);
    p1_c   <= {1'b0, k_prod} - KELVIN_OFFSET;
  end

  logic [46:0] c_abs;
  logic        p2_valid;
  logic        p2_sat;
  logic        p2_neg;
  logic [23:0] p2_y;

  assign c_abs = p1_c[46] ? (47'd0 - p1_c) : p1_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid;
    end
    p2_sat <= p1_sat;
    p2_neg <= p1_c[46];
    p2_y   <= 24'(c_abs[45:23]) + 24'd50;
  end

  logic [39:0] r_prod;
  logic        p3_valid;
  logic        p3_sat;
  logic        p3_neg;
  logic [23:0] p3_y;
  logic [17:0] p3_qe;

  assign r_prod = 40'(p2_y) * 40'(RECIP_100);

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else begin
      p3_valid <= p2_valid;
    end
    p3_sat <= p2_sat;
    p3_neg <= p2_neg;
    p3_y   <= p2_y;
    p3_qe  <= r_prod[39:22];
  end

  logic [24:0] q_rem;
  logic        p4_valid;
  logic        p4_sat;
  logic        p4_neg;
  logic [17:0] p4_q;

  assign q_rem = {1'b0, p3_y} - 25'(25'(p3_qe) * 25'd100);

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_valid <= 1'b0;
    end else begin
      p4_valid <= p3_valid;
    end
    p4_sat <= p3_sat;
    p4_neg <= p3_neg;
    p4_q   <= (q_rem >= 25'd100) ? p3_qe + 18'd1 : p3_qe;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p4_valid;
    end
    if (p4_sat || (!p4_neg && p4_q > 18'd32767)) begin
      temperature_c <= TEMP_MAX;
      saturated     <= 1'b1;
    end else if (p4_neg && p4_q > 18'd32768) begin
      temperature_c <= TEMP_MIN;
      saturated     <= 1'b1;
    end else if (p4_neg) begin
      temperature_c <= 16'(18'd0 - p4_q);
      saturated     <= 1'b0;
    end else begin
      temperature_c <= p4_q[15:0];
      saturated     <= 1'b0;
    end
  end

endmodule

// File: rtl/core/ntc_log2.sv
// Pipelined log2 of ratio numerator and denominator, returning the magnitude and sign of the difference.
module ntc_log2 import ntc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [15:0] num,
  input  logic [15:0] den,
  output logic        out_valid,
  output logval_t     mag,
  output logic        neg
);

  logic [LOG_STEPS:0] vld;
  logic [30:0] mn [0:LOG_STEPS];
  logic [30:0] md [0:LOG_STEPS];
  logval_t     rn [0:LOG_STEPS];
  logval_t     rd [0:LOG_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    mn[0] <= log_norm(num);
    md[0] <= log_norm(den);
    rn[0] <= {msb16(num), 30'b0};
    rd[0] <= {msb16(den), 30'b0};
  end

  for (genvar i = 1; i <= LOG_STEPS; i++) begin : g_step
    logic [61:0] sqn;
    logic [61:0] sqd;
    assign sqn = 62'(mn[i-1]) * 62'(mn[i-1]);
    assign sqd = 62'(md[i-1]) * 62'(md[i-1]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= vld[i-1];
      end
      if (sqn[61]) begin
        mn[i] <= sqn[61:31];
        rn[i] <= rn[i-1] | (34'd1 << (LOG_STEPS - i));
      end else begin
        mn[i] <= sqn[60:30];
        rn[i] <= rn[i-1];
      end
      if (sqd[61]) begin
        md[i] <= sqd[61:31];
        rd[i] <= rd[i-1] | (34'd1 << (LOG_STEPS - i));
      end else begin
        md[i] <= sqd[60:30];
        rd[i] <= rd[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[LOG_STEPS];
    end
    if (rn[LOG_STEPS] >= rd[LOG_STEPS]) begin
      mag <= rn[LOG_STEPS] - rd[LOG_STEPS];
      neg <= 1'b0;
    end else begin
      mag <= rd[LOG_STEPS] - rn[LOG_STEPS];
      neg <= 1'b1;
    end
  end

endmodule

// File: rtl/core/ntc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a one-bit tag alongside.
module ntc_div import ntc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  dword_t   dividend,
  input  divisor_t divisor,
  input  logic     tag_in,
  output logic     out_valid,
  output dword_t   quotient,
  output logic     tag_out
);

  logic [DIV_STAGES-1:0] vld;
  logic [DIV_STAGES-1:0] tag;
  logic [47:0] rem [0:DIV_STAGES-1];
  dword_t      quo [0:DIV_STAGES-1];
  dword_t      dvd [0:DIV_STAGES-1];
  divisor_t    dvs [0:DIV_STAGES-1];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    logic        v_prev;
    logic        t_prev;
    logic [47:0] r_prev;
    dword_t      q_prev;
    dword_t      n_prev;
    divisor_t    d_prev;
    logic [48:0] sh;

    if (j == 0) begin : g_first
      assign v_prev = in_valid;
      assign t_prev = tag_in;
      assign r_prev = 48'd0;
      assign q_prev = 64'd0;
      assign n_prev = dividend;
      assign d_prev = divisor;
    end else begin : g_next
      assign v_prev = vld[j-1];
      assign t_prev = tag[j-1];
      assign r_prev = rem[j-1];
      assign q_prev = quo[j-1];
      assign n_prev = dvd[j-1];
      assign d_prev = dvs[j-1];
    end

    assign sh = {r_prev, n_prev[DIV_STAGES-1-j]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else begin
        vld[j] <= v_prev;
      end
      tag[j] <= t_prev;
      dvd[j] <= n_prev;
      dvs[j] <= d_prev;
      if (sh >= {1'b0, d_prev}) begin
        rem[j] <= 48'(sh - {1'b0, d_prev});
        quo[j] <= {q_prev[62:0], 1'b1};
      end else begin
        rem[j] <= sh[47:0];
        quo[j] <= {q_prev[62:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign quotient  = quo[DIV_STAGES-1];
  assign tag_out   = tag[DIV_STAGES-1];

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the NTC thermistor to Celsius converter.
module testbench;
  import ntc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct {
    logic [11:0] raw;
    int unsigned gap;
  } sample_t;

  typedef struct {
    logic signed [15:0] temp;
    logic sat;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [11:0] raw_sample = '0;
  logic wr_en = 1'b0;
  logic wr_index = REG_BETA;
  logic [15:0] wr_data = '0;
  logic done;
  logic signed [15:0] temperature_c;
  logic saturated;

  sample_t pending[$];
  reading_t readings_due[$];
  logic [13:0] beta_reg = BETA_RESET;
  logic [15:0] t0_reg = T0_RESET;
  logic took = 1'b0;
  int unsigned wait_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned errors = 0;

  ntc_thermistor_to_celsius_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .raw_sample(raw_sample),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data), .done(done),
    .temperature_c(temperature_c), .saturated(saturated)
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] log2_fixed(input logic [63:0] x);
    int k;
    logic [63:0] m;
    logic [63:0] res;
    if (x == 0) x = 1;
    k = 0;
    while (k < 63 && (x >> (k + 1)) != 0) k++;
    m = (k <= 30) ? (x << (30 - k)) : (x >> (k - 30));
    res = 64'(k) << 30;
    for (int b = 29; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        res[b] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic reading_t celsius_of(input logic [11:0] raw);
    logic [63:0] num, den, la, lb, mag, lnmag, term1, term2, beta, t0, tq;
    logic neg;
    longint inv, c, r;
    longint dvs;
    reading_t o;
    dvs = longint'(100) << 23;
    if (64'(raw) * 330 < 64'(SAMPLE_FULL_SCALE)) begin
      num = 1;
      den = 329;
    end else if (64'(raw) * 330 > 64'(329 * SAMPLE_FULL_SCALE)) begin
      num = 329;
      den = 1;
    end else begin
      num = 64'(raw);
      den = 64'(SAMPLE_FULL_SCALE) - 64'(raw);
    end
    la = log2_fixed(num);
    lb = log2_fixed(den);
    neg = la < lb;
    mag = neg ? lb - la : la - lb;
    lnmag = (mag * 64'd744261118) >> 30;
    beta = (beta_reg != 0) ? 64'(beta_reg) : 64'd1;
    t0 = (t0_reg != 0) ? 64'(t0_reg) : 64'd1;
    term1 = (64'd100 << 40) / t0;
    term2 = (lnmag << 10) / beta;
    inv = neg ? longint'(term1) - longint'(term2) : longint'(term1) + longint'(term2);
    o.temp = 16'sh7FFF;
    o.sat = 1'b1;
    if (inv <= 0) return o;
    tq = (64'd1 << 63) / 64'(inv);
    if (tq >= (64'd40000 << 23)) return o;
    c = longint'(tq * 100) - (longint'(27315) << 23);
    if (c >= 0) r = (c + dvs / 2) / dvs;
    else r = -((-c + dvs / 2) / dvs);
    if (r > 32767) o.temp = 16'sh7FFF;
    else if (r < -32768) o.temp = 16'sh8000;
    else begin
      o.temp = 16'(r);
      o.sat = 1'b0;
    end
    return o;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // Driver
  always @(negedge clk) begin
    if (!rst) begin
      if (start && !took) begin
      end else if (took && pending.size() != 0 && pending[0].gap != 0) begin
        start <= 1'b0;
        wait_left <= pending[0].gap - 1;
        pending[0].gap = 0;
      end else if (wait_left != 0) begin
        start <= 1'b0;
        wait_left <= wait_left - 1;
      end else if (pending.size() != 0) begin
        raw_sample <= pending[0].raw;
        start <= 1'b1;
        void'(pending.pop_front());
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    reading_t exp_r;
    if (rst) begin
      took <= 1'b0;
    end else begin
      took <= start && !busy;
      if (start && !busy) readings_due.push_back(celsius_of(raw_sample));
      if (done) begin
        if (readings_due.size() == 0) begin
          report_mismatch("result with no transaction outstanding");
        end else begin
          exp_r = readings_due.pop_front();
          if (temperature_c !== exp_r.temp)
            report_mismatch($sformatf("temperature_c %0d, expected %0d",
                                      temperature_c, exp_r.temp));
          if (saturated !== exp_r.sat)
            report_mismatch($sformatf("saturated %b, expected %b", saturated, exp_r.sat));
        end
      end
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** ntc_thermistor_to_celsius_top: FAILED **");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
    wr_en <= 1'b0;
    if (idx == REG_BETA) beta_reg = val[13:0];
    else t0_reg = val;
  endtask

  task automatic drain;
    while (pending.size() != 0 || start || readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [11:0] pick_raw;
    case ($urandom_range(0, 4))
      0: return 12'($urandom_range(0, 30));
      1: return 12'($urandom_range(4065, 4095));
      2: return 12'($urandom_range(1800, 2300));
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic queue_random(input int n, input bit with_gaps);
    sample_t s;
    for (int i = 0; i < n; i++) begin
      s.raw = pick_raw();
      s.gap = (with_gaps && $urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
      pending.push_back(s);
    end
  endtask

  initial begin
    logic [11:0] directed[$];
    sample_t s;
    directed = '{12'd0, 12'd1, 12'd12, 12'd13, 12'd14, 12'd2047, 12'd2048, 12'd4082,
                 12'd4083, 12'd4084, 12'd4094, 12'd4095, 12'hAAA, 12'h555, 12'd1000,
                 12'd3000};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i]) begin
      s.raw = directed[i];
      s.gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 18);
      pending.push_back(s);
    end
    queue_random(60, 1'b1);
    drain();
    write_reg(REG_BETA, 16'd1000);
    write_reg(REG_T0, 16'd20000);
    foreach (directed[i]) begin
      s.raw = directed[i];
      s.gap = 0;
      pending.push_back(s);
    end
    queue_random(60, 1'b0);
    drain();
    write_reg(REG_BETA, 16'd10000);
    write_reg(REG_T0, 16'd40000);
    queue_random(60, 1'b1);
    drain();
    write_reg(REG_BETA, 16'd0);
    write_reg(REG_T0, 16'd0);
    queue_random(40, 1'b1);
    drain();
    write_reg(REG_BETA, 16'hFFFF);
    write_reg(REG_T0, 16'hFFFF);
    queue_random(40, 1'b1);
    drain();
    write_reg(REG_BETA, 16'd1);
    write_reg(REG_T0, T0_RESET);
    queue_random(40, 1'b1);
    drain();
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_BETA, 16'($urandom_range(0, 65535)));
      write_reg(REG_T0, 16'($urandom_range(0, 65535)));
      queue_random(25, p[0]);
      drain();
    end
    if (errors == 0) begin
      $display("** ntc_thermistor_to_celsius_top: PASSED **");
    end else begin
      $display("** ntc_thermistor_to_celsius_top: FAILED **");
    end
    $finish;
  end
endmodule
